[hdl/amlsc_pkg.sv]
package amlsc_pkg;

    // Lane count and derived index width
    localparam int LANES  = 2;
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

    // Field widths
    localparam int OP_W    = 2;
    localparam int LANEF_W = 4;
    localparam int VEH_W   = 4;
    localparam int TIME_W  = 4;
    localparam int WAIT_W  = 8;
    localparam int PROC_W  = 16;
    localparam int LIGHTS_W = 16;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_ARRIVE   = 2'd1;
    localparam logic [OP_W-1:0] OP_OVERRIDE = 2'd2;

    // Light codes
    localparam logic [1:0] LT_RED    = 2'd0;
    localparam logic [1:0] LT_YELLOW = 2'd1;
    localparam logic [1:0] LT_GREEN  = 2'd2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_TIME    = 2'd3;

    // Reset values
    localparam logic [TIME_W-1:0] RST_GREEN_BASE  = 4'd2;
    localparam logic [TIME_W-1:0] RST_GREEN_MAX   = 4'd5;
    localparam logic [TIME_W-1:0] RST_YELLOW_TIME = 4'd2;
    localparam logic [TIME_W-1:0] RST_RED_TIME    = 4'd2;
    localparam logic [TIME_W-1:0] RST_GREEN_TIME  = 4'd2;
    localparam logic [TIME_W-1:0] ELAPSED_MAX     = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [LANEF_W-1:0] lane;
        logic [VEH_W-1:0]   vehicles;
    } in_item_t;

    typedef struct packed {
        logic [LIGHTS_W-1:0] lights;
        logic                status;
        logic [WAIT_W-1:0]   waiting;
        logic [PROC_W-1:0]   processed;
    } out_item_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INC,
        ST_VISIT,
        ST_APPLY,
        ST_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic inc_all;
        logic visit;
        logic apply;
        logic load_out;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            lane_ok;
        logic            last_lane;
    } dp_stat_t;

endpackage

[hdl/amlsc_ctrl.sv]
module amlsc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output amlsc_pkg::ctl_cmd_t cmd,
    input  amlsc_pkg::dp_stat_t stat
);

    amlsc_pkg::state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    // State and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= amlsc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            amlsc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = amlsc_pkg::ST_DISPATCH;
                end
            end
            amlsc_pkg::ST_DISPATCH: begin
                case (stat.op)
                    amlsc_pkg::OP_TICK: state_next = amlsc_pkg::ST_INC;
                    amlsc_pkg::OP_ARRIVE,
                    amlsc_pkg::OP_OVERRIDE: begin
                        state_next = stat.lane_ok ? amlsc_pkg::ST_APPLY
                                                  : amlsc_pkg::ST_RESULT;
                    end
                    default: state_next = amlsc_pkg::ST_RESULT;
                endcase
            end
            amlsc_pkg::ST_INC: begin
                cmd.inc_all = 1'b1;
                state_next  = amlsc_pkg::ST_VISIT;
            end
            amlsc_pkg::ST_VISIT: begin
                cmd.visit = 1'b1;
                if (stat.last_lane) begin
                    state_next = amlsc_pkg::ST_RESULT;
                end
            end
            amlsc_pkg::ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = amlsc_pkg::ST_RESULT;
            end
            amlsc_pkg::ST_RESULT: begin
                // wait for a free output slot
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = amlsc_pkg::ST_IDLE;
                end
            end
            default: state_next = amlsc_pkg::ST_IDLE;
        endcase
    end

    // Output beat valid
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // A pending beat is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("output beat overwritten");

    // One item in flight at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    // Output valid rises only from the result state
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == amlsc_pkg::ST_RESULT))
        else $error("spurious output beat");

endmodule

[hdl/amlsc_dp.sv]
module amlsc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [amlsc_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [amlsc_pkg::TIME_W-1:0]        cfg_data,
    input  amlsc_pkg::in_item_t                 s_data,
    output amlsc_pkg::out_item_t                m_data,
    input  amlsc_pkg::ctl_cmd_t                 cmd,
    output amlsc_pkg::dp_stat_t                 stat
);

    localparam int LN = amlsc_pkg::LANES;
    localparam int LW = amlsc_pkg::LANE_W;
    localparam int TW = amlsc_pkg::TIME_W;
    localparam int WW = amlsc_pkg::WAIT_W;
    localparam int PW = amlsc_pkg::PROC_W;

    // Config registers
    logic [TW-1:0] green_base_reg, green_max_reg, yellow_time_reg, red_time_reg;

    // Captured item and lane pointer
    amlsc_pkg::in_item_t  item_reg;
    logic [LW-1:0]        idx_reg, idx_next;
    amlsc_pkg::out_item_t out_reg, out_next;

    // Per-lane state
    logic [1:0]    light_reg     [LN];
    logic [1:0]    light_next    [LN];
    logic [TW-1:0] elapsed_reg   [LN];
    logic [TW-1:0] elapsed_next  [LN];
    logic [WW-1:0] waiting_reg   [LN];
    logic [WW-1:0] waiting_next  [LN];
    logic [PW-1:0] proc_reg      [LN];
    logic [PW-1:0] proc_next     [LN];
    logic [TW-1:0] gtime_reg     [LN];
    logic [TW-1:0] gtime_next    [LN];

    logic          lane_ok;
    logic [LW-1:0] lane_idx;
    logic [LW-1:0] rd_idx;
    logic          other_green;
    logic [1:0]    cur_light;
    logic [TW-1:0] cur_elapsed;
    logic [WW-1:0] cur_waiting;
    logic [PW-1:0] cur_proc;
    logic [TW-1:0] cur_gtime;
    logic [PW:0]   proc_sum;
    logic [WW:0]   wait_sum;
    logic [WW-1:0] wait_sat;
    logic [WW:0]   gt_sum;
    logic [TW-1:0] gt_new;
    logic [amlsc_pkg::LIGHTS_W-1:0] lights_vec;

    assign lane_ok  = item_reg.lane < amlsc_pkg::LANEF_W'(LN);
    assign lane_idx = item_reg.lane[LW-1:0];
    assign rd_idx   = cmd.visit ? idx_reg : lane_idx;

    assign stat.op        = item_reg.op;
    assign stat.lane_ok   = lane_ok;
    assign stat.last_lane = (idx_reg == LW'(LN - 1));

    // Single read port at the selected lane
    assign cur_light   = light_reg[rd_idx];
    assign cur_elapsed = elapsed_reg[rd_idx];
    assign cur_waiting = waiting_reg[rd_idx];
    assign cur_proc    = proc_reg[rd_idx];
    assign cur_gtime   = gtime_reg[rd_idx];

    // Any other lane green right now
    always_comb begin
        other_green = 1'b0;
        for (int j = 0; j < LN; j++) begin
            if (LW'(j) != rd_idx && light_reg[j] == amlsc_pkg::LT_GREEN) begin
                other_green = 1'b1;
            end
        end
    end

    // Saturating sums
    assign proc_sum = {1'b0, cur_proc} + (PW + 1)'(cur_waiting);
    assign wait_sum = {1'b0, cur_waiting} + (WW + 1)'(item_reg.vehicles);
    assign wait_sat = wait_sum[WW] ? {WW{1'b1}} : wait_sum[WW-1:0];
    assign gt_sum   = (WW + 1)'(green_base_reg) + (WW + 1)'(wait_sat);
    assign gt_new   = (gt_sum > (WW + 1)'(green_max_reg)) ? green_max_reg
                                                          : gt_sum[TW-1:0];

    // Next per-lane state
    always_comb begin
        for (int i = 0; i < LN; i++) begin
            light_next[i]   = light_reg[i];
            elapsed_next[i] = elapsed_reg[i];
            waiting_next[i] = waiting_reg[i];
            proc_next[i]    = proc_reg[i];
            gtime_next[i]   = gtime_reg[i];
        end
        idx_next = idx_reg;

        if (cmd.capture) begin
            idx_next = '0;
        end

        // tick, first pass: every elapsed count up, saturating
        if (cmd.inc_all) begin
            for (int i = 0; i < LN; i++) begin
                if (elapsed_reg[i] != amlsc_pkg::ELAPSED_MAX) begin
                    elapsed_next[i] = elapsed_reg[i] + TW'(1);
                end
            end
        end

        // tick, lane walk: one lane per cycle
        if (cmd.visit) begin
            idx_next = idx_reg + LW'(1);
            case (cur_light)
                amlsc_pkg::LT_GREEN: begin
                    if (cur_elapsed >= cur_gtime) begin
                        light_next[rd_idx]   = amlsc_pkg::LT_YELLOW;
                        elapsed_next[rd_idx] = '0;
                    end
                end
                amlsc_pkg::LT_YELLOW: begin
                    if (cur_elapsed >= yellow_time_reg) begin
                        light_next[rd_idx]   = amlsc_pkg::LT_RED;
                        elapsed_next[rd_idx] = '0;
                    end
                end
                default: begin
                    if (cur_elapsed >= red_time_reg && !other_green) begin
                        light_next[rd_idx]   = amlsc_pkg::LT_GREEN;
                        elapsed_next[rd_idx] = '0;
                        waiting_next[rd_idx] = '0;
                        proc_next[rd_idx]    = proc_sum[PW] ? {PW{1'b1}}
                                                            : proc_sum[PW-1:0];
                    end
                end
            endcase
        end

        // arrival or override on a valid lane
        if (cmd.apply) begin
            if (item_reg.op == amlsc_pkg::OP_ARRIVE) begin
                waiting_next[rd_idx] = wait_sat;
                gtime_next[rd_idx]   = gt_new;
            end else begin
                for (int i = 0; i < LN; i++) begin
                    elapsed_next[i] = '0;
                    if (LW'(i) == rd_idx) begin
                        light_next[i]   = amlsc_pkg::LT_GREEN;
                        waiting_next[i] = '0;
                    end else begin
                        light_next[i] = amlsc_pkg::LT_RED;
                    end
                end
            end
        end
    end

    // Pack lights, unused lanes read zero
    always_comb begin
        lights_vec = '0;
        for (int i = 0; i < LN; i++) begin
            lights_vec[2*i +: 2] = light_reg[i];
        end
    end

    // Result beat
    always_comb begin
        out_next.lights    = lights_vec;
        out_next.status    = !lane_ok && (item_reg.op == amlsc_pkg::OP_ARRIVE ||
                                          item_reg.op == amlsc_pkg::OP_OVERRIDE);
        out_next.waiting   = lane_ok ? cur_waiting : '0;
        out_next.processed = lane_ok ? cur_proc : '0;
    end

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            green_base_reg  <= amlsc_pkg::RST_GREEN_BASE;
            green_max_reg   <= amlsc_pkg::RST_GREEN_MAX;
            yellow_time_reg <= amlsc_pkg::RST_YELLOW_TIME;
            red_time_reg    <= amlsc_pkg::RST_RED_TIME;
        end else if (cfg_we) begin
            case (cfg_idx)
                amlsc_pkg::REG_GREEN_BASE:  green_base_reg  <= cfg_data;
                amlsc_pkg::REG_GREEN_MAX:   green_max_reg   <= cfg_data;
                amlsc_pkg::REG_YELLOW_TIME: yellow_time_reg <= cfg_data;
                amlsc_pkg::REG_RED_TIME:    red_time_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Lane state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LN; i++) begin
                light_reg[i]   <= amlsc_pkg::LT_RED;
                elapsed_reg[i] <= '0;
                waiting_reg[i] <= '0;
                proc_reg[i]    <= '0;
                gtime_reg[i]   <= amlsc_pkg::RST_GREEN_TIME;
            end
            idx_reg <= '0;
        end else begin
            for (int i = 0; i < LN; i++) begin
                light_reg[i]   <= light_next[i];
                elapsed_reg[i] <= elapsed_next[i];
                waiting_reg[i] <= waiting_next[i];
                proc_reg[i]    <= proc_next[i];
                gtime_reg[i]   <= gtime_next[i];
            end
            idx_reg <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.load_out) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

[hdl/adaptive_multi_lane_signal_controller_core.sv]
// Channel   Direction  Handshake           Payload
// config    in         cfg_we              cfg_idx, cfg_data (4-bit timer registers)
// s_        in         s_valid / s_ready   s_data  (op, lane, vehicles)
// m_        out        m_valid / m_ready   m_data  (lights, status, waiting, processed)
//
// A tick goes from accept through a decode state, an aging state that counts up every
// lane, a light walk of one lane per cycle over a single lane read port, and a state
// that registers the result. Arrival and override use decode, apply and result; op 3
// and bad lanes skip apply. A new item is taken the cycle after the result registers.
// One item is in work at a time; a new item is taken while the last result beat
// still waits on m_ready, and the result stage holds until that beat is taken.
// Reset (aresetn low, synchronous) sets all lanes red with cleared counts and
// reloads the timer registers.
module adaptive_multi_lane_signal_controller_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [amlsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [amlsc_pkg::TIME_W-1:0]     cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  amlsc_pkg::in_item_t              s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output amlsc_pkg::out_item_t             m_data
);

    amlsc_pkg::ctl_cmd_t cmd;
    amlsc_pkg::dp_stat_t stat;

    amlsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    amlsc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_data   (s_data),
        .m_data   (m_data),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
